// ===== hw/rtl/epc_pkg.sv =====
// ----------------------------------------------------------------------------
// epc_pkg
// Shared types, field widths, register map and microcode program of the
// encoder position controller.
// ----------------------------------------------------------------------------
package epc_pkg;

    // Field widths of the stream and register payloads
    localparam int CMD_W    = 2;
    localparam int ADC_W    = 14;
    localparam int DUTY_W   = 11;
    localparam int DAC_W    = 12;
    localparam int POS_W    = 24;
    localparam int TARGET_W = 17;
    localparam int GAIN_W   = 8;
    localparam int LEN_W    = 16;
    localparam int CODE_W   = 14;

    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 48;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    // Register reset values
    localparam logic [TARGET_W-1:0] TARGET_RST = TARGET_W'(65536);
    localparam logic [GAIN_W-1:0]   GAIN_RST   = GAIN_W'(40);
    localparam logic [LEN_W-1:0]    LEN_RST    = LEN_W'(100);
    localparam logic [CODE_W-1:0]   VDD_RST    = CODE_W'(16383);
    localparam logic [CODE_W-1:0]   VSS_RST    = CODE_W'(0);
    localparam logic [CODE_W-1:0]   BIAS_RST   = CODE_W'(8192);

    // Position scale: one metre in units of 2^-16 m
    localparam int UNIT_SHIFT = 16;

    // Input commands
    typedef enum logic [CMD_W-1:0] {
        CMD_EDGE  = 2'd0,
        CMD_TICK  = 2'd1,
        CMD_CALIB = 2'd2
    } cmd_t;

    // Register map (index = paddr / 4)
    typedef enum logic [REG_IDX_W-1:0] {
        REG_TARGET = 3'd0,
        REG_GAIN   = 3'd1,
        REG_LENGTH = 3'd2,
        REG_VDD    = 3'd3,
        REG_VSS    = 3'd4,
        REG_BIAS   = 3'd5
    } reg_idx_t;

    // Datapath operations selected by the control word
    typedef enum logic [3:0] {
        OP_NOP,
        OP_FETCH,
        OP_NUM,
        OP_POS,
        OP_SAT,
        OP_NVAL,
        OP_XVAL,
        OP_DIV_LOAD,
        OP_DIV_STEP,
        OP_DAC,
        OP_EMIT,
        OP_EDGE
    } op_t;

    // Jump conditions
    typedef enum logic [2:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_ITEM,
        COND_NOT_TICK,
        COND_DIV_BUSY,
        COND_OUT_BUSY
    } cond_t;

    localparam int STEP_W = 4;
    typedef logic [STEP_W-1:0] step_t;

    // Program addresses
    localparam step_t S_FETCH    = 4'd0;
    localparam step_t S_DISPATCH = 4'd1;
    localparam step_t S_NUM      = 4'd2;
    localparam step_t S_POS      = 4'd3;
    localparam step_t S_SAT      = 4'd4;
    localparam step_t S_NVAL     = 4'd5;
    localparam step_t S_XVAL     = 4'd6;
    localparam step_t S_DIV_LOAD = 4'd7;
    localparam step_t S_DIV      = 4'd8;
    localparam step_t S_DAC      = 4'd9;
    localparam step_t S_EMIT     = 4'd10;
    localparam step_t S_RETURN   = 4'd11;
    localparam step_t S_EDGE     = 4'd12;

    // One control word: operation, jump condition and jump target.
    // Without a taken jump the step counter advances by one.
    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } ctrl_word_t;

    // Divider control from the sequencer
    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

    // Microcode program
    function automatic ctrl_word_t ucode_rom(input step_t addr);
        ctrl_word_t w;
        w = '{op: OP_NOP, cond: COND_ALWAYS, target: S_FETCH};
        case (addr)
            S_FETCH:    w = '{op: OP_FETCH,    cond: COND_NO_ITEM,  target: S_FETCH};
            S_DISPATCH: w = '{op: OP_NOP,      cond: COND_NOT_TICK, target: S_EDGE};
            S_NUM:      w = '{op: OP_NUM,      cond: COND_NEVER,    target: S_FETCH};
            S_POS:      w = '{op: OP_POS,      cond: COND_NEVER,    target: S_FETCH};
            S_SAT:      w = '{op: OP_SAT,      cond: COND_NEVER,    target: S_FETCH};
            S_NVAL:     w = '{op: OP_NVAL,     cond: COND_NEVER,    target: S_FETCH};
            S_XVAL:     w = '{op: OP_XVAL,     cond: COND_NEVER,    target: S_FETCH};
            S_DIV_LOAD: w = '{op: OP_DIV_LOAD, cond: COND_NEVER,    target: S_FETCH};
            S_DIV:      w = '{op: OP_DIV_STEP, cond: COND_DIV_BUSY, target: S_DIV};
            S_DAC:      w = '{op: OP_DAC,      cond: COND_NEVER,    target: S_FETCH};
            S_EMIT:     w = '{op: OP_EMIT,     cond: COND_OUT_BUSY, target: S_EMIT};
            S_RETURN:   w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: S_FETCH};
            S_EDGE:     w = '{op: OP_EDGE,     cond: COND_ALWAYS,   target: S_FETCH};
            default:    w = '{op: OP_NOP,      cond: COND_ALWAYS,   target: S_FETCH};
        endcase
        return w;
    endfunction

endpackage

// ===== hw/rtl/encoder_position_p_controller.sv =====
// ----------------------------------------------------------------------------
// encoder_position_p_controller
// One-wheel proportional position controller: quadrature edge counter,
// corrected ADC sample to PWM duty and direction, position error to DAC code.
// ----------------------------------------------------------------------------
//
//  channel  direction  transaction                    payload
//  s_*      in         encoder edge / tick / calib    tuser: command
//                                                     tdata: enc_b_level, adc_sample
//  m_*      out        control tick result            tdata: pwm_duty, pwm_reverse,
//                                                            dac_code, position
//  apb      in/out     register write / read          6 registers at 4*i
//
//  A microcoded sequencer runs each item. An encoder or calibration edge is
//  fetched, dispatched and applied in the edge step; a control tick runs the
//  datapath steps and the bit-serial divide of the DAC quotient by the loop gain.
//  Reset (aresetn low, synchronous) restores the registers, clears the edge
//  count and the learned direction. A stalled result waits in the output
//  register while the next edges are still accepted.
//
module encoder_position_p_controller #(
    parameter int PWM_PERIOD     = 1200,
    parameter int DAC_FULL_SCALE = 4095,
    parameter int ADC_BITS       = 14
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    // bit 0 enc_b_level, bits 14:1 adc_sample
    input  logic [epc_pkg::S_DATA_W-1:0]     s_tdata,
    // bits 1:0 command
    input  logic [epc_pkg::CMD_W-1:0]        s_tuser,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // bits 10:0 pwm_duty, 11 pwm_reverse, 23:12 dac_code, 47:24 position
    output logic [epc_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [epc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [epc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [epc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import epc_pkg::*;

    // Derived widths
    localparam int PER_W   = $clog2(PWM_PERIOD + 1);
    localparam int F_W     = $clog2(DAC_FULL_SCALE + 1);
    localparam int PROD_W  = 2 * CODE_W + 2;
    localparam int MAG_W   = 1 + ((ADC_BITS > CODE_W) ? (CODE_W + ADC_BITS) : (2 * CODE_W));
    localparam int NUM_W   = MAG_W + 1;
    localparam int DPROD_W = MAG_W + PER_W;
    localparam int DSUM_W  = DPROD_W + 1;
    localparam int PP_W    = POS_W + LEN_W + 1;
    localparam int DIFF_W  = POS_W + 2;
    localparam int NPROD_W = DIFF_W + GAIN_W + 1;
    localparam int NSUM_W  = NPROD_W + 1;
    localparam int N_W     = 32;
    localparam int X_W     = N_W + F_W + 1;
    localparam int DIV_SH  = UNIT_SHIFT + 1;
    localparam int DIV_W   = X_W - DIV_SH;

    localparam logic [PER_W-1:0]         PERIOD    = PER_W'(PWM_PERIOD);
    localparam logic [F_W-1:0]           FULL      = F_W'(DAC_FULL_SCALE);
    localparam logic [DSUM_W-1:0]        DUTY_HALF = DSUM_W'(1) << (2 * ADC_BITS - 2);
    localparam logic signed [POS_W-1:0]  CNT_MAX   = {1'b0, {(POS_W-1){1'b1}}};
    localparam logic signed [POS_W-1:0]  CNT_MIN   = {1'b1, {(POS_W-1){1'b0}}};
    localparam logic signed [PP_W-1:0]   PP_MAX    = PP_W'(CNT_MAX);
    localparam logic signed [PP_W-1:0]   PP_MIN    = PP_W'(CNT_MIN);
    localparam logic signed [DIFF_W-1:0] ONE_METRE = DIFF_W'(1) <<< UNIT_SHIFT;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [TARGET_W-1:0] target_reg;
    logic [GAIN_W-1:0]   gain_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [CODE_W-1:0]   vdd_reg;
    logic [CODE_W-1:0]   vss_reg;
    logic [CODE_W-1:0]   bias_reg;
    logic                cfg_write;
    reg_idx_t            cfg_idx;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[APB_ADDR_W-1:2]);

    // Write on the access cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= TARGET_RST;
            gain_reg   <= GAIN_RST;
            len_reg    <= LEN_RST;
            vdd_reg    <= VDD_RST;
            vss_reg    <= VSS_RST;
            bias_reg   <= BIAS_RST;
        end else if (cfg_write) begin
            case (cfg_idx)
                REG_TARGET: target_reg <= pwdata[TARGET_W-1:0];
                REG_GAIN:   gain_reg   <= pwdata[GAIN_W-1:0];
                REG_LENGTH: len_reg    <= pwdata[LEN_W-1:0];
                REG_VDD:    vdd_reg    <= pwdata[CODE_W-1:0];
                REG_VSS:    vss_reg    <= pwdata[CODE_W-1:0];
                REG_BIAS:   bias_reg   <= pwdata[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    // Read back
    always_comb begin
        case (cfg_idx)
            REG_TARGET: prdata = APB_DATA_W'(target_reg);
            REG_GAIN:   prdata = APB_DATA_W'(gain_reg);
            REG_LENGTH: prdata = APB_DATA_W'(len_reg);
            REG_VDD:    prdata = APB_DATA_W'(vdd_reg);
            REG_VSS:    prdata = APB_DATA_W'(vss_reg);
            REG_BIAS:   prdata = APB_DATA_W'(bias_reg);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    logic       [STEP_W-1:0] step_reg;
    logic       [STEP_W-1:0] step_next;
    ctrl_word_t              ctrl;
    logic                    jump;
    logic                    div_last;
    logic                    m_tvalid_reg;
    logic       [CMD_W-1:0]  cmd_reg;
    logic                    out_free;

    assign ctrl     = ucode_rom(step_reg);
    assign out_free = !m_tvalid_reg || m_tready;

    // Evaluate the jump condition and pick the next step
    always_comb begin
        case (ctrl.cond)
            COND_NEVER:    jump = 1'b0;
            COND_ALWAYS:   jump = 1'b1;
            COND_NO_ITEM:  jump = !s_tvalid;
            COND_NOT_TICK: jump = (cmd_reg != CMD_TICK);
            COND_DIV_BUSY: jump = !div_last;
            COND_OUT_BUSY: jump = !out_free;
            default:       jump = 1'b0;
        endcase
        step_next = jump ? ctrl.target : step_reg + 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= S_FETCH;
        end else begin
            step_reg <= step_next;
        end
    end

    // ------------------------------------------------------------------
    // Input capture
    // ------------------------------------------------------------------
    logic              s_accept;
    logic              b_reg;
    logic [ADC_W-1:0]  sample_reg;

    assign s_tready = (ctrl.op == OP_FETCH);
    assign s_accept = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            cmd_reg    <= s_tuser;
            b_reg      <= s_tdata[0];
            sample_reg <= s_tdata[ADC_W:1];
        end
    end

    // ------------------------------------------------------------------
    // Edge counter and learned direction
    // ------------------------------------------------------------------
    logic signed [POS_W-1:0] edge_count_reg;
    logic                    fs_valid_reg;
    logic                    fs_neg_reg;
    logic                    count_up;

    assign count_up = (b_reg == fs_neg_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            edge_count_reg <= '0;
            fs_valid_reg   <= 1'b0;
            fs_neg_reg     <= 1'b0;
        end else if (ctrl.op == OP_EDGE) begin
            // count only once the direction is known, saturate at the ends
            if (cmd_reg == CMD_EDGE && fs_valid_reg) begin
                if (count_up && edge_count_reg != CNT_MAX) begin
                    edge_count_reg <= edge_count_reg + 1'b1;
                end else if (!count_up && edge_count_reg != CNT_MIN) begin
                    edge_count_reg <= edge_count_reg - 1'b1;
                end
            end else if (cmd_reg == CMD_CALIB) begin
                fs_valid_reg <= 1'b1;
                fs_neg_reg   <= b_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic signed [CODE_W:0]   span;
    logic signed [CODE_W:0]   offset;
    logic signed [PROD_W-1:0] samp_prod;
    logic signed [NUM_W-1:0]  num_calc;
    logic        [MAG_W-1:0]  mag_calc;
    logic signed [PP_W-1:0]   pp_calc;
    logic signed [POS_W-1:0]  pos_sat;
    logic        [DPROD_W-1:0] dprod_calc;
    logic        [DSUM_W-1:0] duty_sum;
    logic        [DSUM_W-1:0] duty_q;
    logic        [DSUM_W-1:0] duty_cap;
    logic        [GAIN_W-1:0] gain_eff;
    logic signed [DIFF_W-1:0] diff;
    logic signed [NPROD_W-1:0] nprod;
    logic signed [NSUM_W-1:0] n_calc;
    logic        [N_W+F_W-1:0] xprod;
    logic        [X_W-1:0]    x_calc;
    logic        [DIV_W-1:0]  quotient;
    logic        [DIV_W-1:0]  dac_cap;

    logic signed [NUM_W-1:0]  num_reg;
    logic        [MAG_W-1:0]  mag_reg;
    logic                     rev_reg;
    logic signed [PP_W-1:0]   pp_reg;
    logic signed [POS_W-1:0]  pos_reg;
    logic        [DPROD_W-1:0] dprod_reg;
    logic        [DUTY_W-1:0] duty_reg;
    logic signed [NSUM_W-1:0] n_reg;
    logic        [X_W-1:0]    x_reg;
    logic                     npos_reg;
    logic        [DAC_W-1:0]  dac_reg;
    logic        [M_DATA_W-1:0] m_tdata_reg;
    div_ctrl_t                div_ctrl;

    // Corrected voltage: s*(vdd-vss) - (bias-vss)*2^ADC_BITS
    always_comb begin
        span      = $signed({1'b0, vdd_reg}) - $signed({1'b0, vss_reg});
        offset    = $signed({1'b0, bias_reg}) - $signed({1'b0, vss_reg});
        samp_prod = $signed({1'b0, sample_reg}) * span;
        num_calc  = NUM_W'(samp_prod) - (NUM_W'(offset) <<< ADC_BITS);
    end

    // Magnitude, edge product, duty product
    always_comb begin
        mag_calc   = num_reg[NUM_W-1] ? MAG_W'(-num_reg) : MAG_W'(num_reg);
        pp_calc    = edge_count_reg * $signed({1'b0, len_reg});
        dprod_calc = mag_reg * PERIOD;
        if (pp_reg > PP_MAX) begin
            pos_sat = CNT_MAX;
        end else if (pp_reg < PP_MIN) begin
            pos_sat = CNT_MIN;
        end else begin
            pos_sat = pp_reg[POS_W-1:0];
        end
    end

    // Duty rounded half up and capped; DAC numerator
    always_comb begin
        duty_sum = DSUM_W'(dprod_reg) + DUTY_HALF;
        duty_q   = duty_sum >> (2 * ADC_BITS - 1);
        duty_cap = (duty_q > DSUM_W'(PERIOD)) ? DSUM_W'(PERIOD) : duty_q;
        gain_eff = (gain_reg == '0) ? GAIN_W'(1) : gain_reg;
        diff     = ONE_METRE - DIFF_W'(pos_reg);
        nprod    = diff * $signed({1'b0, gain_eff});
        n_calc   = NSUM_W'(nprod) + NSUM_W'($signed({1'b0, target_reg}));
        xprod    = n_reg[N_W-1:0] * FULL;
        x_calc   = X_W'(xprod) + (X_W'(gain_eff) << UNIT_SHIFT);
        dac_cap  = (quotient > DIV_W'(FULL)) ? DIV_W'(FULL) : quotient;
    end

    // Register each operation's result
    always_ff @(posedge aclk) begin
        case (ctrl.op)
            OP_NUM: begin
                num_reg <= num_calc;
            end
            OP_POS: begin
                mag_reg <= mag_calc;
                rev_reg <= num_reg[NUM_W-1] || (num_reg == '0);
                pp_reg  <= pp_calc;
            end
            OP_SAT: begin
                pos_reg   <= pos_sat;
                dprod_reg <= dprod_calc;
            end
            OP_NVAL: begin
                duty_reg <= duty_cap[DUTY_W-1:0];
                n_reg    <= n_calc;
            end
            OP_XVAL: begin
                x_reg    <= x_calc;
                npos_reg <= !n_reg[NSUM_W-1] && (n_reg != '0);
            end
            OP_DAC: begin
                dac_reg <= npos_reg ? dac_cap[DAC_W-1:0] : '0;
            end
            default: ;
        endcase
    end

    // Divide (n*F + 2^16*G) / 2^17 by the gain
    always_comb begin
        div_ctrl.load = (ctrl.op == OP_DIV_LOAD);
        div_ctrl.step = (ctrl.op == OP_DIV_STEP);
    end

    epc_div #(
        .DIVIDEND_W (DIV_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (div_ctrl),
        .dividend (x_reg[X_W-1:DIV_SH]),
        .divisor  (gain_eff),
        .quotient (quotient),
        .last     (div_last)
    );

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    logic emit;

    assign emit = (ctrl.op == OP_EMIT) && out_free;

    always_ff @(posedge aclk) begin
        if (emit) begin
            m_tdata_reg <= {pos_reg, dac_reg, rev_reg, duty_reg};
        end
    end

    // Hold the transaction until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== hw/rtl/epc_div.sv =====
// ----------------------------------------------------------------------------
// epc_div
// Restoring divider, one quotient bit per step, unsigned dividend by the
// 8-bit loop gain.
// ----------------------------------------------------------------------------
module epc_div #(
    parameter int DIVIDEND_W = 28
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  epc_pkg::div_ctrl_t           ctrl,
    input  logic [DIVIDEND_W-1:0]        dividend,
    input  logic [epc_pkg::GAIN_W-1:0]   divisor,
    output logic [DIVIDEND_W-1:0]        quotient,
    output logic                         last
);
    import epc_pkg::*;

    localparam int CNT_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIVIDEND_W - 1);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [GAIN_W-1:0]     rem_reg;
    logic [CNT_W-1:0]      cnt_reg;

    logic [GAIN_W:0]       shifted;
    logic [GAIN_W:0]       diff;
    logic                  fits;
    logic [GAIN_W-1:0]     rem_next;
    logic [DIVIDEND_W-1:0] quo_next;

    // Trial subtract of the divisor from the partial remainder
    always_comb begin
        shifted  = {rem_reg, quo_reg[DIVIDEND_W-1]};
        diff     = shifted - {1'b0, divisor};
        fits     = (shifted >= {1'b0, divisor});
        rem_next = fits ? diff[GAIN_W-1:0] : shifted[GAIN_W-1:0];
        quo_next = {quo_reg[DIVIDEND_W-2:0], fits};
    end

    // Hold the dividend, shift in one quotient bit per step
    always_ff @(posedge aclk) begin
        if (ctrl.load) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (ctrl.step) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    // Count steps
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (ctrl.load) begin
            cnt_reg <= '0;
        end else if (ctrl.step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign quotient = quo_reg;
    assign last     = (cnt_reg == CNT_LAST);

endmodule

// ===== tb/sv/position_loop_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// position_loop_checker
// Watches the register port and both stream channels of the position
// controller. Keeps its own copy of the registers, the edge count and the
// learned direction, predicts the result of every control tick and compares
// each delivered result field by field, in order.
// ----------------------------------------------------------------------------
module position_loop_checker (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [epc_pkg::S_DATA_W-1:0]   s_tdata,
    input  logic [epc_pkg::CMD_W-1:0]      s_tuser,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [epc_pkg::M_DATA_W-1:0]   m_tdata,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [epc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [epc_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                           pready,
    output int                             error_count,
    output int                             results_pending
);
    import epc_pkg::*;

    localparam longint PWM_PERIOD     = 1200;
    localparam longint DAC_FULL_SCALE = 4095;
    localparam longint ADC_SCALE      = 64'd1 << ADC_W;
    localparam longint ONE_METRE      = 64'd1 << UNIT_SHIFT;
    localparam longint POS_MAX        = (64'd1 << (POS_W - 1)) - 1;
    localparam longint POS_MIN        = -(64'sd1 <<< (POS_W - 1));
    localparam int     REPORT_LIMIT   = 10;

    typedef struct packed {
        logic [DUTY_W-1:0] duty;
        logic              reverse;
        logic [DAC_W-1:0]  dac;
        logic [POS_W-1:0]  position;
    } tick_result_t;

    // Shadow registers and controller state
    logic [TARGET_W-1:0] target;
    logic [GAIN_W-1:0]   gain;
    logic [LEN_W-1:0]    edge_len;
    logic [CODE_W-1:0]   vdd;
    logic [CODE_W-1:0]   vss;
    logic [CODE_W-1:0]   bias;
    longint              edge_count;
    int                  forward_dir;

    tick_result_t        tick_results[$];

    function automatic longint clamp_position(input longint v);
        if (v > POS_MAX) return POS_MAX;
        if (v < POS_MIN) return POS_MIN;
        return v;
    endfunction

    // Duty and direction from the corrected sample, DAC code from the position
    function automatic tick_result_t predict_tick(input logic [ADC_W-1:0] sample);
        longint       num;
        longint       mag;
        longint       duty;
        longint       pos;
        longint       g;
        longint       n;
        longint       q;
        tick_result_t r;
        num = longint'(sample) * (longint'(vdd) - longint'(vss))
            - (longint'(bias) - longint'(vss)) * ADC_SCALE;
        mag = (num < 0) ? -num : num;
        duty = (mag * PWM_PERIOD + ADC_SCALE * ADC_SCALE / 4) / (ADC_SCALE * ADC_SCALE / 2);
        if (duty > PWM_PERIOD) duty = PWM_PERIOD;
        pos = clamp_position(edge_count * longint'(edge_len));
        g = (gain == '0) ? 1 : longint'(gain);
        n = g * (ONE_METRE - pos) + longint'(target);
        if (n <= 0) begin
            q = 0;
        end else begin
            q = (n * DAC_FULL_SCALE + ONE_METRE * g) / (2 * ONE_METRE * g);
            if (q > DAC_FULL_SCALE) q = DAC_FULL_SCALE;
        end
        r.duty     = duty[DUTY_W-1:0];
        r.reverse  = (num > 0) ? 1'b0 : 1'b1;
        r.dac      = q[DAC_W-1:0];
        r.position = pos[POS_W-1:0];
        return r;
    endfunction

    // Count one encoder edge once the forward direction is known
    function automatic void advance_edge_count(input logic b_high);
        longint step;
        if (forward_dir != 0) begin
            step = b_high ? -forward_dir : forward_dir;
            edge_count = clamp_position(edge_count + step);
        end
    endfunction

    function automatic void check_result(input logic [M_DATA_W-1:0] data);
        tick_result_t want;
        tick_result_t got;
        got.duty     = data[10:0];
        got.reverse  = data[11];
        got.dac      = data[23:12];
        got.position = data[47:24];
        if (tick_results.size() == 0) begin
            if (error_count < REPORT_LIMIT)
                $display("unexpected result: duty %0d reverse %0d dac %0d position %0d",
                         got.duty, got.reverse, got.dac, $signed(got.position));
            error_count++;
            return;
        end
        want = tick_results.pop_front();
        if (got.duty !== want.duty || got.reverse !== want.reverse ||
            got.dac !== want.dac || got.position !== want.position) begin
            if (error_count < REPORT_LIMIT)
                $display({"mismatch (expected/actual): duty %0d/%0d reverse %0d/%0d ",
                          "dac %0d/%0d position %0d/%0d"},
                         want.duty, got.duty, want.reverse, got.reverse,
                         want.dac, got.dac, $signed(want.position), $signed(got.position));
            error_count++;
        end
    endfunction

    // Track register writes, predict on accepted inputs, check accepted results
    always @(posedge aclk) begin
        if (!aresetn) begin
            target      = TARGET_RST;
            gain        = GAIN_RST;
            edge_len    = LEN_RST;
            vdd         = VDD_RST;
            vss         = VSS_RST;
            bias        = BIAS_RST;
            edge_count  = 0;
            forward_dir = 0;
            tick_results.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[APB_ADDR_W-1:2]))
                    REG_TARGET: target   = pwdata[TARGET_W-1:0];
                    REG_GAIN:   gain     = pwdata[GAIN_W-1:0];
                    REG_LENGTH: edge_len = pwdata[LEN_W-1:0];
                    REG_VDD:    vdd      = pwdata[CODE_W-1:0];
                    REG_VSS:    vss      = pwdata[CODE_W-1:0];
                    REG_BIAS:   bias     = pwdata[CODE_W-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (s_tvalid && s_tready) begin
                case (s_tuser)
                    CMD_EDGE:  advance_edge_count(s_tdata[0]);
                    CMD_CALIB: forward_dir = s_tdata[0] ? -1 : 1;
                    CMD_TICK:  tick_results.push_back(predict_tick(s_tdata[ADC_W:1]));
                    default: ;
                endcase
            end
        end
        results_pending <= tick_results.size();
    end

endmodule

// ===== tb/sv/encoder_position_p_controller_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// encoder_position_p_controller_test
// Drives encoder edges, calibration edges and control ticks into the position
// controller under several register settings, with random gaps and output
// stalls, and gives the verdict from the checker's error count.
// ----------------------------------------------------------------------------
module encoder_position_p_controller_test;
    import epc_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [ADC_W-1:0] ADC_MAX    = '1;
    localparam int PHASES       = 7;
    localparam int PHASE_ITEMS  = 232;
    localparam int DRAIN_SETTLE = 16;
    localparam int END_SETTLE   = 50;

    logic                  aclk;
    logic                  aresetn;
    logic [S_DATA_W-1:0]   s_tdata;
    logic [CMD_W-1:0]      s_tuser;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [M_DATA_W-1:0]   m_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int error_count;
    int results_pending;

    // Idle control shared by sender and receiver
    bit quiet;
    int send_gap_pct;
    int stall_pct;
    int stall_left;
    int b_high_pct;

    encoder_position_p_controller DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tdata  (m_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    position_loop_checker u_check (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .m_tdata         (m_tdata),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .error_count     (error_count),
        .results_pending (results_pending)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // Stall the result channel in random bursts
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left <= 0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(99) < stall_pct) begin
            m_tready   <= 1'b0;
            stall_left <= $urandom_range(5, 0);
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Present one transaction, maybe after a gap, and hold it until accepted
    task automatic send_item(input logic [CMD_W-1:0] cmd, input logic b_high,
                             input logic [ADC_W-1:0] sample);
        if (!quiet && $urandom_range(99) < send_gap_pct) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {1'b0, sample, b_high};
        do @(posedge aclk); while (!s_tready);
    endtask

    // Stop sending and wait for every expected result plus a settle time
    task automatic drain(input int settle);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (results_pending != 0) @(posedge aclk);
        repeat (settle) @(posedge aclk);
    endtask

    task automatic reg_write(input reg_idx_t idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    task automatic program_setting(input logic [APB_DATA_W-1:0] target,
                                   input logic [APB_DATA_W-1:0] gain,
                                   input logic [APB_DATA_W-1:0] length,
                                   input logic [APB_DATA_W-1:0] vdd,
                                   input logic [APB_DATA_W-1:0] vss,
                                   input logic [APB_DATA_W-1:0] bias);
        reg_write(REG_TARGET, target);
        reg_write(REG_GAIN, gain);
        reg_write(REG_LENGTH, length);
        reg_write(REG_VDD, vdd);
        reg_write(REG_VSS, vss);
        reg_write(REG_BIAS, bias);
    endtask

    // Mostly edges and ticks, some recalibration, a few unused commands
    task automatic send_random_items(input int count);
        int                 pick;
        int                 adc_pick;
        logic [CMD_W-1:0]   cmd;
        logic [ADC_W-1:0]   sample;
        for (int i = 0; i < count; i++) begin
            pick     = $urandom_range(99);
            adc_pick = $urandom_range(9);
            if (pick < 50)      cmd = CMD_EDGE;
            else if (pick < 85) cmd = CMD_TICK;
            else if (pick < 95) cmd = CMD_CALIB;
            else                cmd = CMD_UNUSED;
            if (adc_pick == 0)      sample = '0;
            else if (adc_pick == 1) sample = ADC_MAX;
            else                    sample = ADC_W'($urandom());
            send_item(cmd, $urandom_range(99) < b_high_pct, sample);
        end
    endtask

    // Main stimulus
    initial begin
        aresetn      <= 1'b0;
        s_tvalid     <= 1'b0;
        s_tuser      <= CMD_EDGE;
        s_tdata      <= '0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        quiet        = 1'b0;
        send_gap_pct = 20;
        stall_pct    = 20;
        b_high_pct   = 50;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: edges before calibration, both directions, field extremes
        send_item(CMD_TICK, 1'b0, '0);
        send_item(CMD_EDGE, 1'b0, ADC_MAX);
        send_item(CMD_EDGE, 1'b1, '0);
        send_item(CMD_UNUSED, 1'b1, ADC_MAX);
        send_item(CMD_TICK, 1'b1, ADC_MAX);
        send_item(CMD_CALIB, 1'b0, '0);
        repeat (3) send_item(CMD_EDGE, 1'b0, '0);
        send_item(CMD_EDGE, 1'b1, '0);
        send_item(CMD_TICK, 1'b0, ADC_W'(8192));
        send_item(CMD_CALIB, 1'b1, '0);
        repeat (5) send_item(CMD_EDGE, 1'b0, '0);
        send_item(CMD_TICK, 1'b0, ADC_W'(8191));
        send_item(CMD_TICK, 1'b1, ADC_W'(1));
        send_item(CMD_UNUSED, 1'b0, '0);
        send_item(CMD_TICK, 1'b0, ADC_W'(8193));

        for (int phase = 1; phase <= PHASES; phase++) begin
            drain(DRAIN_SETTLE);
            case (phase)
                // zero gain, longest edge, equal codes for zero voltage
                1: program_setting(0, 0, 65535, 5000, 5000, 5000);
                // widest target, top gain, zero edge length
                2: program_setting(131071, 255, 0, 16383, 0, 0);
                // inverted supply codes, unit edge length
                3: program_setting(65536, 1, 1, 0, 16383, 16383);
                default: program_setting($urandom(), $urandom(),
                                         ($urandom_range(3) == 0) ? $urandom()
                                                                  : $urandom_range(300),
                                         $urandom(), $urandom(), $urandom());
            endcase
            b_high_pct = $urandom_range(90, 10);
            case ($urandom_range(2))
                0:       begin send_gap_pct = 0;  stall_pct = 0;  end
                1:       begin send_gap_pct = 15; stall_pct = 25; end
                default: begin send_gap_pct = 40; stall_pct = 40; end
            endcase
            if (phase == PHASES) quiet = 1'b1;
            send_random_items(PHASE_ITEMS);
        end

        drain(END_SETTLE);
        if (error_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    // Hang guard
    initial begin
        #5_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
